@@ rtl/mkd_pkg.sv @@
`default_nettype none

package mkd_pkg;

    // Configuration register width and indexes
    localparam int CFG_W = 16;

    localparam logic [1:0] CFG_IDX_WINDOW = 2'd0;
    localparam logic [1:0] CFG_IDX_HOLD   = 2'd1;
    localparam logic [1:0] CFG_IDX_REARM  = 2'd2;

    localparam logic [CFG_W-1:0] WINDOW_RST = 16'd225;
    localparam logic [CFG_W-1:0] HOLD_RST   = 16'd200;
    localparam logic [CFG_W-1:0] REARM_RST  = 16'd50;

    // Characters
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_DASH  = 7'h2D;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_HASH  = 7'h23;

    // Symbol code: bits 7..5 count symbols, one increment per symbol
    localparam logic [7:0] CODE_STEP = 8'h20;

    // Output queue
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = 3;

    typedef struct packed {
        logic [CFG_W-1:0] window;
        logic [CFG_W-1:0] hold;
        logic [CFG_W-1:0] rearm;
    } cfg_t;

    // Characters produced by one tick: cnt is 0, 1 or 2
    typedef struct packed {
        logic [1:0] cnt;
        logic [6:0] ch0;
        logic [6:0] ch1;
    } res_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } entry_t;

    // Map a symbol code to its letter; unknown codes keep the previous letter
    function automatic logic [6:0] decode_letter(input logic [7:0] code,
                                                 input logic [6:0] prev);
        logic [6:0] ch;
        ch = prev;
        unique case (code)
            8'h00: ch = CH_HASH;
            8'h20: ch = 7'("E");
            8'h21: ch = 7'("T");
            8'h42: ch = 7'("A");
            8'h40: ch = 7'("I");
            8'h43: ch = 7'("M");
            8'h41: ch = 7'("N");
            8'h61: ch = 7'("D");
            8'h63: ch = 7'("G");
            8'h65: ch = 7'("K");
            8'h67: ch = 7'("O");
            8'h62: ch = 7'("R");
            8'h60: ch = 7'("S");
            8'h64: ch = 7'("U");
            8'h66: ch = 7'("W");
            8'h81: ch = 7'("B");
            8'h85: ch = 7'("C");
            8'h84: ch = 7'("F");
            8'h80: ch = 7'("H");
            8'h8E: ch = 7'("J");
            8'h82: ch = 7'("L");
            8'h86: ch = 7'("P");
            8'h8B: ch = 7'("Q");
            8'h88: ch = 7'("V");
            8'h89: ch = 7'("X");
            8'h8D: ch = 7'("Y");
            8'h83: ch = 7'("Z");
            8'h8A: ch = CH_SPACE;
            default: ch = prev;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mkd_fsm.sv @@
`default_nettype none

module mkd_fsm #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          tick_vld,
    input  wire logic          key,
    input  wire logic          commit,
    input  wire mkd_pkg::cfg_t cfg,
    output mkd_pkg::res_t      res
);
    import mkd_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_KEY    = 2'd1;
    localparam logic [1:0] PH_COMMIT = 2'd2;
    localparam logic [1:0] PH_HOLD   = 2'd3;

    localparam int LW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [LW-1:0] MASK_L = LW'((64'd1 << TIMER_BITS) - 64'd1);
    localparam logic [TIMER_BITS-1:0] TMR_MAX = {TIMER_BITS{1'b1}};

    logic [1:0]            phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [7:0]            code_reg, code_next;
    logic [6:0]            prev_reg, prev_next;
    logic                  armed_reg, armed_next;
    logic [CFG_W-1:0]      rel_reg, rel_next;

    logic [TIMER_BITS-1:0] timer_inc;
    logic [TIMER_BITS-1:0] win_lim;
    logic [TIMER_BITS-1:0] hold_lim;
    logic [LW-1:0]         win_ext;
    logic [LW-1:0]         hold_ext;
    logic [CFG_W-1:0]      rel_inc;
    logic [7:0]            pos_bit;
    logic [7:0]            code_sym;
    logic [6:0]            letter;
    logic [1:0]            after_action;

    // Clip limits to the timer range
    assign win_ext  = LW'(cfg.window);
    assign hold_ext = LW'(cfg.hold);
    assign win_lim  = (win_ext > MASK_L) ? TMR_MAX : win_ext[TIMER_BITS-1:0];
    assign hold_lim = (hold_ext > MASK_L) ? TMR_MAX : hold_ext[TIMER_BITS-1:0];

    // Saturating timer advance
    assign timer_inc = (timer_reg == TMR_MAX) ? timer_reg : timer_reg + 1'b1;

    assign rel_inc = (rel_reg < cfg.rearm) ? rel_reg + 1'b1 : rel_reg;

    // Symbol update: set or clear the dash bit, then count the symbol
    assign pos_bit  = 8'd1 << code_reg[7:5];
    assign code_sym = (key ? (code_reg | pos_bit) : (code_reg & ~pos_bit)) + CODE_STEP;

    assign letter       = decode_letter(code_reg, prev_reg);
    assign after_action = (cfg.hold == '0) ? PH_IDLE : PH_HOLD;

    // Advance the phase machine on each tick
    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        code_next  = code_reg;
        prev_next  = prev_reg;
        armed_next = armed_reg;
        rel_next   = rel_reg;
        res        = '0;
        if (tick_vld)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (commit)
                    begin
                        phase_next = PH_COMMIT;
                        timer_next = '0;
                    end
                    else if (key && armed_reg)
                    begin
                        armed_next = 1'b0;
                        phase_next = PH_KEY;
                        timer_next = '0;
                    end
                    if (key)
                    begin
                        rel_next = '0;
                    end
                    else
                    begin
                        rel_next = rel_inc;
                        if (rel_inc >= cfg.rearm)
                        begin
                            armed_next = 1'b1;
                        end
                    end
                end
                PH_KEY:
                begin
                    timer_next = timer_inc;
                    if (timer_inc >= win_lim)
                    begin
                        code_next  = code_sym;
                        res.cnt    = 2'd1;
                        res.ch0    = key ? CH_DASH : CH_DOT;
                        timer_next = '0;
                        phase_next = after_action;
                    end
                end
                PH_COMMIT:
                begin
                    timer_next = timer_inc;
                    if (timer_inc >= win_lim)
                    begin
                        if (commit)
                        begin
                            res.cnt = 2'd2;
                            res.ch0 = CH_SPACE;
                            res.ch1 = letter;
                        end
                        else
                        begin
                            res.cnt = 2'd1;
                            res.ch0 = letter;
                        end
                        prev_next  = letter;
                        code_next  = '0;
                        timer_next = '0;
                        phase_next = after_action;
                    end
                end
                default:
                begin
                    timer_next = timer_inc;
                    if (timer_inc >= hold_lim)
                    begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            code_reg  <= '0;
            prev_reg  <= CH_SPACE;
            armed_reg <= 1'b1;
            rel_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            code_reg  <= code_next;
            prev_reg  <= prev_next;
            armed_reg <= armed_next;
            rel_reg   <= rel_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mkd_queue.sv @@
`default_nettype none

module mkd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mkd_pkg::res_t        res,
    input  wire logic                 pop,
    output logic                      vld,
    output mkd_pkg::entry_t           head,
    output logic [mkd_pkg::Q_AW:0]    count
);
    import mkd_pkg::*;

    entry_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_reg, wr_next;
    logic [Q_AW-1:0] rd_reg, rd_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;
    logic [Q_AW-1:0] wr_plus1;
    logic            do_pop;

    assign vld      = (cnt_reg != '0);
    assign head     = mem_reg[rd_reg];
    assign count    = cnt_reg;
    assign do_pop   = pop && vld;
    assign wr_plus1 = wr_reg + 1'b1;

    // Advance pointers and fill level
    always_comb
    begin
        wr_next  = wr_reg + Q_AW'(res.cnt);
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (Q_AW+1)'(res.cnt) - (Q_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the characters of one tick; the last one carries the run flag
    always_ff @(posedge clk)
    begin
        if (res.cnt != 2'd0)
        begin
            mem_reg[wr_reg] <= '{ch: res.ch0, last: (res.cnt == 2'd1)};
        end
        if (res.cnt == 2'd2)
        begin
            mem_reg[wr_plus1] <= '{ch: res.ch1, last: 1'b1};
        end
    end

endmodule

`default_nettype wire

@@ rtl/morse_key_decoder.sv @@
// Morse key decoder.
// Input channel (in_valid / in_stall): one tick item per cycle unless
// in_stall is high, with the key and commit button levels. Output channel
// (out_valid / out_stall): the characters sent, '.', '-', a space, a letter
// or '#'; last_of_run marks the final character caused by one tick (a held
// commit gives a space, then the letter).
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 press
// window, 1 hold period, 2 re-arm run length; index 3 is ignored. Write only
// while no item is in flight.
// An accepted tick is captured in the input register; from there the decoder
// state updates and its characters enter the output queue together, so they
// reach the output through the input register and the queue. Throughput is
// one tick per cycle while in_stall is low, set by the single state update step.
// Characters wait in an eight-entry output queue. in_stall rises when the
// queue could not hold the characters of the tick in the input register plus
// those of a new one, so output stalls back up to the input without loss.
// Reset clears the queue and restores the register defaults (225, 200, 50),
// an empty code, a space as previous letter and an armed key.
`default_nettype none

module morse_key_decoder #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        key_level,
    input  wire logic        commit_level,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [6:0]       out_char,
    output logic             last_of_run,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import mkd_pkg::*;

    cfg_t          cfg_reg;
    logic          in_vld_reg;
    logic          key_reg;
    logic          commit_reg;
    logic          in_acc;
    logic          cfg_wr;
    res_t          res;
    entry_t        head;
    logic [Q_AW:0] q_count;
    logic [Q_AW+1:0] need;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Stall when the queue may not fit two ticks' worth of characters
    assign need     = (Q_AW+2)'(q_count) + (in_vld_reg ? (Q_AW+2)'(2) : '0) + (Q_AW+2)'(2);
    assign in_stall = (need > (Q_AW+2)'(Q_DEPTH));
    assign in_acc   = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window <= WINDOW_RST;
            cfg_reg.hold   <= HOLD_RST;
            cfg_reg.rearm  <= REARM_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_IDX_WINDOW: cfg_reg.window <= cfg_data;
                CFG_IDX_HOLD:   cfg_reg.hold   <= cfg_data;
                CFG_IDX_REARM:  cfg_reg.rearm  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            key_reg    <= key_level;
            commit_reg <= commit_level;
        end
    end

    mkd_fsm #(
        .TIMER_BITS (TIMER_BITS)
    ) u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick_vld (in_vld_reg),
        .key      (key_reg),
        .commit   (commit_reg),
        .cfg      (cfg_reg),
        .res      (res)
    );

    mkd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res),
        .pop   (!out_stall),
        .vld   (out_valid),
        .head  (head),
        .count (q_count)
    );

    assign out_char    = head.ch;
    assign last_of_run = head.last;

endmodule

`default_nettype wire

@@ rtl/mkd_checker.sv @@
`default_nettype none

module mkd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [6:0] out_char,
    input wire logic       last_of_run
);

    // Hold a stalled item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_of_run))
        else $error("stalled output item changed");

    // Only a space may precede the letter of the same tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> out_char == 7'h20)
        else $error("non-final character is not a space");

    // The letter is queued together with its leading space
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("letter missing after space");

    // Input backpressure only with characters waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last_of_run (last_of_run)
);

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import mkd_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 2_000_000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned PHASE_ITEMS     = 60;
    localparam logic [1:0]  CFG_IDX_SPARE   = 2'd3;
    localparam int unsigned TIMER_MAX       = 16'hFFFF;
    localparam logic [6:0]  CH_E            = 7'h45;

    // Letter table: code bytes and their characters, first entry in the top byte
    localparam logic [27*8-1:0] MORSE_CODES = {
        8'h20, 8'h21, 8'h42, 8'h40, 8'h43, 8'h41, 8'h61, 8'h63, 8'h65,
        8'h67, 8'h62, 8'h60, 8'h64, 8'h66, 8'h81, 8'h85, 8'h84, 8'h80,
        8'h8E, 8'h82, 8'h86, 8'h8B, 8'h88, 8'h89, 8'h8D, 8'h83, 8'h8A
    };
    localparam logic [27*8-1:0] MORSE_CHARS = "ETAIMNDGKORSUWBCFHJLPQVXYZ ";

    typedef enum logic [1:0] {KP_IDLE, KP_KEY, KP_COMMIT, KP_HOLD} keyer_phase_e;
    typedef enum logic {ROW_TICKS, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } char_item_t;

    typedef struct {
        row_kind_e   kind;
        bit          key;
        bit          commit;
        int unsigned reps;
        bit          typed;
        int unsigned n;
        char_item_t  want0;
        char_item_t  want1;
        logic [15:0] cfg_w;
        logic [15:0] cfg_h;
        logic [15:0] cfg_r;
    } plan_row_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        key_level    = 1'b0;
    logic        commit_level = 1'b0;
    logic        out_stall    = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [1:0]  cfg_index    = CFG_IDX_WINDOW;
    logic [15:0] cfg_data     = 16'd0;
    logic        in_stall;
    logic        out_valid;
    logic [6:0]  out_char;
    logic        last_of_run;
    logic        cfg_ready;

    // Keyer model state and its copy of the registers
    logic [15:0]  win_ticks   = WINDOW_RST;
    logic [15:0]  hold_len    = HOLD_RST;
    logic [15:0]  rearm_len   = REARM_RST;
    logic [7:0]   sym_code    = 8'h00;
    logic [6:0]   last_letter = CH_SPACE;
    keyer_phase_e kphase      = KP_IDLE;
    int unsigned  ktimer      = 0;
    bit           armed       = 1'b1;
    int unsigned  released    = 0;

    char_item_t  step_out [2];
    int unsigned step_n;

    char_item_t  pending_chars [$];
    plan_row_t   plan [$];
    int unsigned row_at;
    int unsigned busy_ticks  = 0;
    int unsigned mismatches  = 0;
    int unsigned cycles      = 0;
    bit          steady      = 1'b0;
    bit          hold_off_req = 1'b0;

    morse_key_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_level    (key_level),
        .commit_level (commit_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .last_of_run  (last_of_run),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic logic [6:0] letter_for_code(input logic [7:0] code);
        logic [6:0] ch;
        ch = last_letter;
        if (code == 8'h00)
            ch = CH_HASH;
        else
            for (int i = 0; i < 27; i++)
                if (MORSE_CODES[8*(26-i) +: 8] == code)
                    ch = MORSE_CHARS[8*(26-i) +: 7];
        return ch;
    endfunction

    // Advance the window timer; true on the sampling tick
    function automatic bit window_elapsed();
        if (ktimer < TIMER_MAX)
            ktimer++;
        return ktimer >= win_ticks;
    endfunction

    // Work out the characters that one accepted tick sends
    task automatic keyer_step(input bit key, input bit commit);
        logic [7:0] bit_mask;
        logic [6:0] letter;
        step_n = 0;
        case (kphase)
            KP_IDLE:
            begin
                if (commit)
                begin
                    kphase = KP_COMMIT;
                    ktimer = 0;
                end
                else if (key && armed)
                begin
                    armed  = 1'b0;
                    kphase = KP_KEY;
                    ktimer = 0;
                end
                if (key)
                    released = 0;
                else
                begin
                    if (released < rearm_len)
                        released++;
                    if (released >= rearm_len)
                        armed = 1'b1;
                end
            end
            KP_KEY:
            begin
                if (window_elapsed())
                begin
                    bit_mask = 8'h01 << sym_code[7:5];
                    sym_code = key ? (sym_code | bit_mask) : (sym_code & ~bit_mask);
                    sym_code = sym_code + CODE_STEP;
                    step_out[0] = {key ? CH_DASH : CH_DOT, 1'b1};
                    step_n = 1;
                    ktimer = 0;
                    kphase = (hold_len == 0) ? KP_IDLE : KP_HOLD;
                end
            end
            KP_COMMIT:
            begin
                if (window_elapsed())
                begin
                    letter = letter_for_code(sym_code);
                    if (commit)
                    begin
                        step_out[0] = {CH_SPACE, 1'b0};
                        step_n = 1;
                    end
                    step_out[step_n] = {letter, 1'b1};
                    step_n++;
                    last_letter = letter;
                    sym_code = 8'h00;
                    ktimer = 0;
                    kphase = (hold_len == 0) ? KP_IDLE : KP_HOLD;
                end
            end
            KP_HOLD:
            begin
                ktimer++;
                if (ktimer >= hold_len)
                begin
                    kphase = KP_IDLE;
                    ktimer = 0;
                end
            end
        endcase
    endtask

    // Offer one tick, wait for it to be taken, then queue what it sends
    task automatic send_tick(input bit key, input bit commit, input bit from_row);
        bit counted;
        in_valid     <= 1'b1;
        key_level    <= key;
        commit_level <= commit;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        counted = (kphase != KP_HOLD);
        keyer_step(key, commit);
        if (counted)
            busy_ticks++;
        if (from_row)
        begin
            for (int i = 0; i < plan[row_at].n; i++)
                pending_chars.push_back(i == 0 ? plan[row_at].want0 : plan[row_at].want1);
        end
        else
        begin
            for (int i = 0; i < step_n; i++)
                pending_chars.push_back(step_out[i]);
        end
        if (!steady && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Stop offering ticks and let every character come out
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_IDX_WINDOW: win_ticks = val;
            CFG_IDX_HOLD:   hold_len  = val;
            CFG_IDX_REARM:  rearm_len = val;
            default:        ;
        endcase
    endtask

    task automatic load_config(input logic [15:0] w, input logic [15:0] h,
                               input logic [15:0] r);
        settle();
        write_reg(CFG_IDX_WINDOW, w);
        write_reg(CFG_IDX_HOLD, h);
        write_reg(CFG_IDX_REARM, r);
        write_reg(CFG_IDX_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_ticks(input bit key, input bit commit,
                                      input int unsigned reps);
        plan_row_t r;
        r.kind   = ROW_TICKS;
        r.key    = key;
        r.commit = commit;
        r.reps   = reps;
        r.typed  = 1'b0;
        r.n      = 0;
        r.want0  = '0;
        r.want1  = '0;
        r.cfg_w  = '0;
        r.cfg_h  = '0;
        r.cfg_r  = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_typed(input bit key, input bit commit,
                                      input int unsigned reps, input int unsigned n,
                                      input char_item_t w0, input char_item_t w1);
        add_ticks(key, commit, reps);
        plan[plan.size()-1].typed = 1'b1;
        plan[plan.size()-1].n     = n;
        plan[plan.size()-1].want0 = w0;
        plan[plan.size()-1].want1 = w1;
    endfunction

    function automatic void add_cfg(input logic [15:0] w, input logic [15:0] h,
                                    input logic [15:0] r);
        add_ticks(1'b0, 1'b0, 0);
        plan[plan.size()-1].kind  = ROW_CFG;
        plan[plan.size()-1].cfg_w = w;
        plan[plan.size()-1].cfg_h = h;
        plan[plan.size()-1].cfg_r = r;
    endfunction

    // Take characters and compare them with the oldest expectation
    initial
    begin
        char_item_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_chars.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, got char %h last %b",
                             $time, out_char, last_of_run);
                    mismatches++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (out_char !== want.ch)
                    begin
                        $display("%0t: out_char expected %h got %h", $time, want.ch, out_char);
                        mismatches++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $display("%0t: last_of_run expected %b got %b",
                                 $time, want.last, last_of_run);
                        mismatches++;
                    end
                end
            end
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus
    initial
    begin
        int unsigned start_count;
        int unsigned run;
        int unsigned eff_win;
        int unsigned pick;
        bit          dash;

        // Reset values: held commit on an empty code gives a space, then '#'
        add_ticks(1'b0, 1'b1, 1);
        add_ticks(1'b0, 1'b1, 224);
        add_typed(1'b0, 1'b1, 1, 2, {CH_SPACE, 1'b0}, {CH_HASH, 1'b1});
        // Longest window and re-arm run: the press waits, a shorter window samples it
        add_cfg(16'hFFFF, 16'd0, 16'hFFFF);
        add_ticks(1'b0, 1'b0, 1);
        add_ticks(1'b1, 1'b0, 3);
        add_cfg(16'd2, 16'd0, 16'd0);
        add_typed(1'b0, 1'b0, 1, 1, {CH_DOT, 1'b1}, {CH_DOT, 1'b1});
        add_ticks(1'b0, 1'b0, 1);
        // Longest hold after a held commit: the lone dot decodes to E
        add_cfg(16'd2, 16'hFFFF, 16'd0);
        add_ticks(1'b0, 1'b1, 2);
        add_typed(1'b0, 1'b1, 1, 2, {CH_SPACE, 1'b0}, {CH_E, 1'b1});
        add_ticks(1'b0, 1'b0, 3);
        // Shortest timing: space code (dot dash dot dash), released commit
        add_cfg(16'd1, 16'd0, 16'd0);
        add_ticks(1'b0, 1'b0, 1);
        for (int i = 0; i < 4; i++)
        begin
            dash = i[0];
            add_ticks(1'b1, 1'b0, 1 + dash);
            add_ticks(1'b0, 1'b0, 2 - dash);
        end
        add_ticks(1'b0, 1'b1, 1);
        add_ticks(1'b0, 1'b0, 1);
        // Unknown code keeps the previous letter; held commit adds a space
        for (int i = 0; i < 5; i++)
        begin
            add_ticks(1'b1, 1'b0, 2);
            add_ticks(1'b0, 1'b0, 1);
        end
        add_ticks(1'b0, 1'b1, 2);
        // More than seven symbols: the count wraps
        for (int i = 0; i < 9; i++)
        begin
            dash = (i % 3 == 0);
            add_ticks(1'b1, 1'b0, 1 + dash);
            add_ticks(1'b0, 1'b0, 2 - dash);
        end
        add_ticks(1'b0, 1'b1, 1);
        add_ticks(1'b0, 1'b0, 1);
        // Both buttons at once: commit wins
        add_ticks(1'b1, 1'b1, 2);
        add_ticks(1'b0, 1'b0, 1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (row_at = 0; row_at < plan.size(); row_at++)
        begin
            if (plan[row_at].kind == ROW_CFG)
                load_config(plan[row_at].cfg_w, plan[row_at].cfg_h, plan[row_at].cfg_r);
            else
                for (int i = 0; i < plan[row_at].reps; i++)
                    send_tick(plan[row_at].key, plan[row_at].commit,
                              plan[row_at].typed && (i == plan[row_at].reps - 1));
        end

        // Random phases: zero window, random settings, a pressure phase, quiet end
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       load_config(16'd0, 16'd0, 16'd0);
                2:       load_config(16'd1, 16'd0, 16'd0);
                default: load_config(16'($urandom_range(1, 6)), 16'($urandom_range(0, 5)),
                                     16'($urandom_range(0, 5)));
            endcase
            if (ph == 2)
            begin
                // Stop taking characters while dots keep coming
                steady = 1'b1;
                hold_off_req = 1'b1;
                repeat (40)
                begin
                    send_tick(1'b1, 1'b0, 1'b0);
                    send_tick(1'b0, 1'b0, 1'b0);
                    send_tick(1'b0, 1'b0, 1'b0);
                end
                steady = 1'b0;
            end
            if (ph == 3)
                steady = 1'b1;
            eff_win = (win_ticks == 0) ? 1 : win_ticks;
            start_count = busy_ticks;
            while (busy_ticks - start_count < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 11);
                if (pick <= 6)
                begin
                    // Symbol: press of random length, then a release run
                    run = $urandom_range(1, eff_win + 2);
                    repeat (run) send_tick(1'b1, 1'b0, 1'b0);
                    run = $urandom_range(1, hold_len + rearm_len + 3);
                    repeat (run) send_tick(1'b0, 1'b0, 1'b0);
                end
                else if (pick <= 9)
                begin
                    // Commit: press of random length, then a release run
                    run = $urandom_range(1, eff_win + 2);
                    repeat (run) send_tick(1'b0, 1'b1, 1'b0);
                    run = $urandom_range(1, hold_len + 2);
                    repeat (run) send_tick(1'b0, 1'b0, 1'b0);
                end
                else if (pick == 10)
                begin
                    run = $urandom_range(1, 8);
                    repeat (run) send_tick($urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
                end
                else
                begin
                    run = $urandom_range(1, eff_win + 2);
                    repeat (run) send_tick(1'b1, 1'b1, 1'b0);
                end
            end
        end

        // Drain and report
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
